// ----- hw/rtl/smfr_pkg.sv -----
package smfr_pkg;

  // frame phase codes
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  // line end pattern codes
  localparam logic [1:0] LE_OTHER = 2'd0;
  localparam logic [1:0] LE_R     = 2'd1;
  localparam logic [1:0] LE_RN    = 2'd2;
  localparam logic [1:0] LE_RNR   = 2'd3;

  // value parse codes
  localparam logic [1:0] VP_IDLE   = 2'd0;
  localparam logic [1:0] VP_NAME   = 2'd1;
  localparam logic [1:0] VP_COLON  = 2'd2;
  localparam logic [1:0] VP_DIGITS = 2'd3;

  localparam logic [3:0] NAME_LEN = 4'd14;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5a;
  localparam logic [7:0] CH_C     = 8'h43;

  typedef struct packed {
    logic [1:0] line_end;
    logic [3:0] name_idx;
    logic [1:0] value_ph;
    logic       len_found;
  } hdr_state_t;

  typedef struct packed {
    logic end_no_body;
    logic go_body;
  } hdr_event_t;

  // characters of the header name "Content-Length"
  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6f; // o
      4'd2:    c = 8'h6e; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6e; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2d; // -
      4'd8:    c = 8'h4c; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6e; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/smfr_hdr_parse.sv -----
module smfr_hdr_parse
  import smfr_pkg::*;
#(
  parameter int LenWidth = 16
) (
  input  logic [7:0]          byte_i,
  input  hdr_state_t          st_i,
  input  logic [LenWidth-1:0] len_i,
  input  logic                bad_i,
  output hdr_state_t          st_o,
  output logic [LenWidth-1:0] len_o,
  output logic                bad_o,
  output hdr_event_t          ev_o
);

  localparam int WideW = LenWidth + 4;

  logic              is_blank;
  logic              is_digit;
  logic              handled;
  logic [WideW-1:0]  len_wide;
  logic [WideW-1:0]  len_next;
  logic [WideW-1:0]  len_max;

  assign is_blank = (byte_i == CH_SP) || (byte_i == CH_TAB);
  assign is_digit = (byte_i >= CH_0) && (byte_i <= CH_9);
  assign len_wide = WideW'(len_i);
  assign len_max  = WideW'({LenWidth{1'b1}});
  // value times ten plus the digit
  assign len_next = (len_wide << 3) + (len_wide << 1) + WideW'(byte_i - CH_0);

  always_comb begin
    st_o    = st_i;
    len_o   = len_i;
    bad_o   = bad_i;
    ev_o    = '0;
    handled = 1'b0;

    if (st_i.value_ph != VP_IDLE) begin
      if (is_blank) begin
        if (st_i.value_ph == VP_DIGITS) st_o.value_ph = VP_IDLE;
        st_o.line_end = LE_OTHER;
        handled = 1'b1;
      end else if (byte_i == CH_COLON && st_i.value_ph != VP_DIGITS) begin
        st_o.value_ph = VP_COLON;
        st_o.line_end = LE_OTHER;
        handled = 1'b1;
      end else if (is_digit) begin
        if (len_next > len_max) begin
          len_o = {LenWidth{1'b1}};
          bad_o = 1'b1;
        end else begin
          len_o = len_next[LenWidth-1:0];
        end
        st_o.len_found = 1'b1;
        st_o.value_ph  = VP_DIGITS;
        st_o.line_end  = LE_OTHER;
        handled = 1'b1;
      end else begin
        if (byte_i != CH_CR) bad_o = 1'b1;
        st_o.value_ph = VP_IDLE;
      end
    end

    if (!handled) begin
      if (byte_i == CH_CR) begin
        st_o.name_idx = '0;
        if (st_i.line_end == LE_OTHER) begin
          st_o.line_end = LE_R;
        end else if (st_i.line_end == LE_RN) begin
          st_o.line_end = LE_RNR;
        end else begin
          bad_o = 1'b1;
          st_o.line_end = LE_OTHER;
        end
      end else if (byte_i == CH_LF) begin
        st_o.name_idx = '0;
        if (st_i.line_end == LE_R) begin
          st_o.line_end = LE_RN;
        end else if (st_i.line_end == LE_RNR) begin
          st_o.line_end = LE_OTHER;
          if (len_i == '0) ev_o.end_no_body = 1'b1;
          else             ev_o.go_body     = 1'b1;
        end else begin
          bad_o = 1'b1;
          st_o.line_end = LE_OTHER;
        end
      end else begin
        st_o.line_end = LE_OTHER;
        if (st_i.name_idx != '0 && st_i.name_idx < NAME_LEN) begin
          if (byte_i == name_char(st_i.name_idx)) begin
            if (st_i.name_idx + 4'd1 >= NAME_LEN) begin
              st_o.name_idx = '0;
              st_o.value_ph = VP_NAME;
            end else begin
              st_o.name_idx = st_i.name_idx + 4'd1;
            end
          end else begin
            st_o.name_idx = '0;
          end
        end else begin
          st_o.name_idx = '0;
          // a match starts only on C right after a line end
          if (byte_i == CH_C && st_i.line_end == LE_RN && !st_i.len_found)
            st_o.name_idx = 4'd1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/sip_stream_message_framer_unit.sv -----
// channel  | dir | handshake                   | payload
// s_axis   | in  | s_axis_tvalid_i/tready_o    | tdata[7:0] data_byte
// m_axis   | out | m_axis_tvalid_o/tready_i    | tdata byte_out, body_length;
//          |     |                             | tuser flags; tlast last_of_message
// cfg      | in  | cfg_we_i                    | cfg_wdata_i max_msg_bytes
//
// one byte per cycle: each byte is parsed in the cycle it is accepted and its
// result lands in the output register, so a new transfer is taken every cycle
// while the output register is empty or being drained.
// the output register stalls the input side only while it holds a result and m_axis_tready_i is low.
// reset clears the parser state and sets max_msg_bytes to 65535.
module sip_stream_message_framer_unit
  import smfr_pkg::*;
#(
  parameter int LenWidth = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,       // max_msg_bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,    // [7:0] data_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,    // [7:0] byte_out, [23:8] body_length
  output logic [2:0]  m_axis_tuser_o,    // [0] in_message, [1] first_of_message,
                                         // [2] bad_message
  output logic        m_axis_tlast_o
);

  localparam int CmpW = (LenWidth > 16) ? LenWidth : 16;

  logic [15:0]         max_q;
  logic [1:0]          phase_q, phase_d;
  hdr_state_t          hst_q, hst_d, hst_par;
  logic [LenWidth-1:0] len_q, len_d, len_par;
  logic [LenWidth-1:0] rem_q, rem_d;
  logic                bad_q, bad_d, bad_par;
  logic [15:0]         cnt_q, cnt_d;
  hdr_event_t          ev;

  logic                inmsg, first, last;
  logic [CmpW-1:0]     len_ext;
  logic [15:0]         len_sat;

  logic                vld_q;
  logic [7:0]          byte_q;
  logic [15:0]         blen_q;
  logic [2:0]          user_q;
  logic                last_q;
  logic                accept;

  assign s_axis_tready_o = !vld_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  smfr_hdr_parse #(
    .LenWidth(LenWidth)
  ) u_hdr (
    .byte_i(s_axis_tdata_i),
    .st_i  (hst_q),
    .len_i (len_q),
    .bad_i (bad_q),
    .st_o  (hst_par),
    .len_o (len_par),
    .bad_o (bad_par),
    .ev_o  (ev)
  );

  always_comb begin
    phase_d = phase_q;
    hst_d   = hst_q;
    len_d   = len_q;
    rem_d   = rem_q;
    bad_d   = bad_q;
    cnt_d   = cnt_q;
    inmsg   = 1'b0;
    first   = 1'b0;
    last    = 1'b0;

    if (phase_q == PH_BODY) begin
      inmsg = 1'b1;
      cnt_d = cnt_q + 16'd1;
      if (rem_q <= LenWidth'(1)) begin
        rem_d   = '0;
        phase_d = PH_HUNT;
        last    = 1'b1;
      end else begin
        rem_d = rem_q - LenWidth'(1);
      end
    end else if (phase_q == PH_HEAD) begin
      inmsg = 1'b1;
      cnt_d = cnt_q + 16'd1;
      hst_d = hst_par;
      len_d = len_par;
      bad_d = bad_par;
      if (ev.end_no_body) begin
        phase_d = PH_HUNT;
        last    = 1'b1;
      end else if (ev.go_body) begin
        phase_d = PH_BODY;
        rem_d   = len_q;
      end
    end else if (s_axis_tdata_i >= CH_A && s_axis_tdata_i <= CH_Z) begin
      inmsg   = 1'b1;
      first   = 1'b1;
      phase_d = PH_HEAD;
      hst_d   = '{line_end: LE_OTHER, name_idx: 4'd0, value_ph: VP_IDLE, len_found: 1'b0};
      len_d   = '0;
      rem_d   = '0;
      bad_d   = 1'b0;
      cnt_d   = 16'd1;
    end else begin
      phase_d = PH_HUNT;
    end

    // size limit closes a message that has not ended yet
    if (inmsg && !last && cnt_d >= max_q) begin
      last           = 1'b1;
      bad_d          = 1'b1;
      phase_d        = PH_HUNT;
      rem_d          = '0;
      hst_d.value_ph = VP_IDLE;
      hst_d.name_idx = '0;
    end
  end

  assign len_ext = CmpW'(len_d);
  assign len_sat = (len_ext > CmpW'(16'hffff)) ? 16'hffff : len_ext[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= 16'hffff;
      phase_q <= PH_HUNT;
      hst_q   <= '{line_end: LE_OTHER, name_idx: 4'd0, value_ph: VP_IDLE, len_found: 1'b0};
      len_q   <= '0;
      rem_q   <= '0;
      bad_q   <= 1'b0;
      cnt_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) max_q <= cfg_wdata_i;
      if (accept) begin
        phase_q <= phase_d;
        hst_q   <= hst_d;
        len_q   <= len_d;
        rem_q   <= rem_d;
        bad_q   <= bad_d;
        cnt_q   <= cnt_d;
        vld_q   <= 1'b1;
      end else if (m_axis_tready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= s_axis_tdata_i;
      blen_q <= inmsg ? len_sat : 16'd0;
      user_q <= {inmsg & bad_d, first, inmsg};
      last_q <= last;
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = {blen_q, byte_q};
  assign m_axis_tuser_o  = user_q;
  assign m_axis_tlast_o  = last_q;

endmodule

// ----- bench/frame_mark_checker.sv -----
module frame_mark_checker
  import smfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,
  input  logic [2:0]  m_tuser_i,
  input  logic        m_tlast_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o,
  output int          frames_o,
  output int          bad_frames_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  byte_val;
    logic        in_msg;
    logic        first;
    logic        last;
    logic        bad;
    logic [15:0] body_len;
  } byte_marks_t;

  localparam logic [8*14-1:0] HDR_NAME = "Content-Length";
  localparam logic [31:0]     LEN_MAX  = 32'd65535;

  // framer state as the block should hold it
  logic [1:0]  phase      = PH_HUNT;
  logic [1:0]  line_end   = LE_OTHER;
  logic [3:0]  name_idx   = '0;
  logic [1:0]  value_ph   = VP_IDLE;
  logic        len_found  = 1'b0;
  logic [15:0] clen       = '0;
  logic [15:0] body_left  = '0;
  logic        bad        = 1'b0;
  logic [15:0] byte_cnt   = '0;
  logic [15:0] max_bytes  = 16'hffff;

  byte_marks_t expected_marks_q[$];
  int error_count = 0;
  int checked_count = 0;
  int frame_count = 0;
  int bad_frame_count = 0;
  int pending_count = 0;

  assign errors_o     = error_count;
  assign pending_o    = pending_count;
  assign checked_o    = checked_count;
  assign frames_o     = frame_count;
  assign bad_frames_o = bad_frame_count;

  function automatic byte_marks_t mark_byte(input logic [7:0] b);
    byte_marks_t r;
    logic [1:0]  prev;
    logic [31:0] v;
    logic        done;
    r = '0;
    r.byte_val = b;
    done = 1'b0;
    if (phase == PH_BODY) begin
      r.in_msg = 1'b1;
      byte_cnt = byte_cnt + 16'd1;
      if (body_left <= 16'd1) begin
        body_left = '0;
        phase = PH_HUNT;
        r.last = 1'b1;
      end else begin
        body_left = body_left - 16'd1;
      end
    end else if (phase == PH_HEAD) begin
      r.in_msg = 1'b1;
      byte_cnt = byte_cnt + 16'd1;
      prev = line_end;
      if (value_ph != VP_IDLE) begin
        if (b == CH_SP || b == CH_TAB) begin
          if (value_ph == VP_DIGITS) value_ph = VP_IDLE;
          line_end = LE_OTHER;
          done = 1'b1;
        end else if (b == CH_COLON && value_ph != VP_DIGITS) begin
          value_ph = VP_COLON;
          line_end = LE_OTHER;
          done = 1'b1;
        end else if (b >= CH_0 && b <= CH_9) begin
          v = 32'(clen) * 32'd10 + 32'(b) - 32'(CH_0);
          if (v > LEN_MAX) begin
            v = LEN_MAX;
            bad = 1'b1;
          end
          clen = v[15:0];
          len_found = 1'b1;
          value_ph = VP_DIGITS;
          line_end = LE_OTHER;
          done = 1'b1;
        end else begin
          // anything but CR breaks the value, then falls through as a normal byte
          if (b != CH_CR) bad = 1'b1;
          value_ph = VP_IDLE;
        end
      end
      if (!done) begin
        if (b == CH_CR) begin
          name_idx = '0;
          if (prev == LE_OTHER) begin
            line_end = LE_R;
          end else if (prev == LE_RN) begin
            line_end = LE_RNR;
          end else begin
            bad = 1'b1;
            line_end = LE_OTHER;
          end
        end else if (b == CH_LF) begin
          name_idx = '0;
          if (prev == LE_R) begin
            line_end = LE_RN;
          end else if (prev == LE_RNR) begin
            line_end = LE_OTHER;
            if (clen == '0) begin
              phase = PH_HUNT;
              r.last = 1'b1;
            end else begin
              phase = PH_BODY;
              body_left = clen;
            end
          end else begin
            bad = 1'b1;
            line_end = LE_OTHER;
          end
        end else begin
          line_end = LE_OTHER;
          if (name_idx > 4'd0 && name_idx < NAME_LEN) begin
            if (b == HDR_NAME[8*(13-int'(name_idx)) +: 8]) begin
              name_idx = name_idx + 4'd1;
              if (name_idx >= NAME_LEN) begin
                name_idx = '0;
                value_ph = VP_NAME;
              end
            end else begin
              name_idx = '0;
            end
          end else begin
            name_idx = '0;
            // only the first content-length header of a message counts
            if (b == CH_C && prev == LE_RN && !len_found) name_idx = 4'd1;
          end
        end
      end
    end else if (b >= CH_A && b <= CH_Z) begin
      r.in_msg = 1'b1;
      r.first = 1'b1;
      phase = PH_HEAD;
      line_end = LE_OTHER;
      name_idx = '0;
      value_ph = VP_IDLE;
      len_found = 1'b0;
      clen = '0;
      body_left = '0;
      bad = 1'b0;
      byte_cnt = 16'd1;
    end else begin
      phase = PH_HUNT;
    end

    // size limit closes an unfinished message
    if (r.in_msg && !r.last && byte_cnt >= max_bytes) begin
      r.last = 1'b1;
      bad = 1'b1;
      phase = PH_HUNT;
      body_left = '0;
      value_ph = VP_IDLE;
      name_idx = '0;
    end
    r.bad = r.in_msg ? bad : 1'b0;
    r.body_len = r.in_msg ? clen : '0;
    return r;
  endfunction

  always @(posedge clk_i) begin : watch
    byte_marks_t got, want;
    if (rst_ni) begin
      if (cfg_we_i) max_bytes = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) expected_marks_q.push_back(mark_byte(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got.byte_val = m_tdata_i[7:0];
        got.body_len = m_tdata_i[23:8];
        got.in_msg   = m_tuser_i[0];
        got.first    = m_tuser_i[1];
        got.bad      = m_tuser_i[2];
        got.last     = m_tlast_i;
        if (expected_marks_q.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: data %02h len %0d msg/first/last/bad %b%b%b%b",
                     got.byte_val, got.body_len, got.in_msg, got.first, got.last, got.bad);
        end else begin
          want = expected_marks_q.pop_front();
          checked_count++;
          if (want.last) begin
            frame_count++;
            if (want.bad) bad_frame_count++;
          end
          if (got !== want) begin
            error_count++;
            // data/len/msg first last bad
            if (error_count <= 10)
              $display("result %0d mismatch: expected %02h/%0d/%b%b%b%b got %02h/%0d/%b%b%b%b",
                       checked_count, want.byte_val, want.body_len, want.in_msg,
                       want.first, want.last, want.bad, got.byte_val, got.body_len,
                       got.in_msg, got.first, got.last, got.bad);
          end
        end
      end
      pending_count = expected_marks_q.size();
    end
  end

endmodule

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smfr_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = '0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;
  logic [2:0]  m_user;
  logic        m_last;

  int errors, pending, checked, frames, bad_frames;
  logic [7:0]  burst_q[$];
  logic [15:0] limit_now = 16'hffff;
  int          sent_count = 0;
  bit          quiet = 1'b0;

  sip_stream_message_framer_unit uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last)
  );

  frame_mark_checker marks_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .s_tvalid_i  (s_valid),
    .s_tready_i  (s_ready),
    .s_tdata_i   (s_data),
    .m_tvalid_i  (m_valid),
    .m_tready_i  (m_ready),
    .m_tdata_i   (m_data),
    .m_tuser_i   (m_user),
    .m_tlast_i   (m_last),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked),
    .frames_o    (frames),
    .bad_frames_o(bad_frames)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // output side: random stall before each transfer
  initial begin : drain
    int stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_ready <= 1'b1;
      @(posedge clk);
      while (!m_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data <= b;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_burst();
    while (burst_q.size() > 0) send_byte(burst_q.pop_front());
  endtask

  // register write only once every result is out
  task automatic set_limit(input logic [15:0] lim);
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= lim;
    @(negedge clk);
    cfg_we <= 1'b0;
    limit_now = lim;
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) burst_q.push_back(s[i]);
  endfunction

  function automatic void add_line(input string s);
    add_text(s);
    burst_q.push_back(CH_CR);
    burst_q.push_back(CH_LF);
  endfunction

  function automatic void add_message();
    int  hdrs, kind, v, body_len;
    bit  have_len;
    have_len = 1'b0;
    body_len = $urandom_range(0, 6);
    burst_q.push_back(CH_A + 8'($urandom_range(0, 25)));
    repeat ($urandom_range(0, 5)) burst_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
    add_line("");
    hdrs = $urandom_range(0, 3);
    for (int h = 0; h < hdrs; h++) begin
      kind = $urandom_range(0, 11);
      v = (limit_now > 16'd1000) ? $urandom_range(0, 24) : $urandom_range(0, 90);
      // a saturated length would run for 64k bytes under a large limit
      if (kind == 8 && limit_now > 16'd1000) kind = 0;
      case (kind)
        0: add_line($sformatf("Content-Length: %0d", v));
        1: add_line($sformatf("Content-Length:%0d", v));
        2: add_line($sformatf("Content-Length \t: \t%0d \tx", v));
        3: add_line($sformatf("Content-Length::0%0d", v));
        4: add_line($sformatf("Content-Length %0d", v));
        5: add_line("Content-Length:");
        6: add_line($sformatf("Content-Length: %0dz", v));
        7: begin
          add_text($sformatf("Content-Length: %0d", v));
          burst_q.push_back(CH_LF);
        end
        8: add_line($sformatf("Content-Length: %0d",
                              $urandom_range(0, 1) ? 65535 : $urandom_range(65536, 999999)));
        9: add_line("Content-Type: a");
        10: add_line("Content-Lengtx: 3");
        default: add_line("Via: x");
      endcase
      if (!have_len && kind <= 5) begin
        have_len = 1'b1;
        body_len = (kind == 5) ? 0 : v;
      end
    end
    add_line("");
    repeat (body_len) burst_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic run_phase(input logic [15:0] lim, input int n_bytes);
    int         start_count;
    logic [7:0] junk;
    set_limit(lim);
    start_count = sent_count;
    while (sent_count - start_count < n_bytes) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) burst_q.push_back(8'($urandom_range(0, 255)));
      add_message();
      // broken messages: a stray line end or random byte, or a cut-off tail
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0: junk = CH_CR;
          1: junk = CH_LF;
          default: junk = 8'($urandom_range(0, 255));
        endcase
        burst_q[$urandom_range(0, burst_q.size() - 1)] = junk;
      end
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, burst_q.size() - 1)) void'(burst_q.pop_back());
      send_burst();
    end
  endtask

  initial begin : stimulus
    int leftover, waited;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // junk around the letter range, doubled CR and bare LF, empty message
    burst_q = '{8'h00, 8'hff, CH_A - 8'd1, CH_Z + 8'd1,
                CH_Z, CH_CR, CH_CR, CH_LF, CH_CR, CH_LF, CH_CR, CH_LF,
                CH_A, CH_CR, CH_LF, CH_CR, CH_LF};
    send_burst();

    run_phase(16'hffff, 240);
    run_phase(16'd64, 200);
    run_phase(16'($urandom_range(65, 400)), 150);
    run_phase(16'd1, 30);
    run_phase(16'd0, 30);
    run_phase(16'($urandom_range(2, 12)), 60);
    run_phase(16'hffff, 80);

    s_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    leftover = pending;
    if (leftover != 0) $display("%0d expected results never arrived", leftover);
    $display("%0d bytes sent, %0d results checked, %0d messages closed (%0d flagged bad)",
             sent_count, checked, frames, bad_frames);
    $display("size limits 0, 1, small, 64, mid and 65535; length values clean, malformed, saturated");
    if (errors == 0 && leftover == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
